// ----- hw/rtl/brs_pkg.sv -----
// Shared constants and types for the bridged run segmenter.
// No dependencies; imported by the top level and its port checker.
package brs_pkg;

   localparam int CFG_BITS          = 28;
   localparam int OUT_BITS          = 28;
   localparam int POSITION_BITS_DEF = 28;

   localparam logic [CFG_BITS-1:0] MIN_LENGTH_RST = CFG_BITS'(10000);
   localparam logic [CFG_BITS-1:0] MAX_BRIDGE_RST = CFG_BITS'(600000);

   // position classes
   localparam logic [1:0] SYM_EMPTY  = 2'd0;
   localparam logic [1:0] SYM_REGION = 2'd1;
   localparam logic [1:0] SYM_PAD    = 2'd2;

   // register indexes on the csr port
   localparam logic CSR_MIN_LENGTH = 1'b0;
   localparam logic CSR_MAX_BRIDGE = 1'b1;

   // result queue
   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = QPTR_BITS + 1;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_REGION    = 4'b0010,
      ST_PAD       = 4'b0100,
      ST_PAD_AFTER = 4'b1000
   } state_type;

endpackage

// ----- hw/rtl/bridged_run_segmenter.sv -----
// Bridged run segmenter: top level with scan state machine and result queue.
// Depends on brs_pkg.
//
// Usage:
//   req_*  : one position class per word (symbol 0 empty, 1 region, 2 pad) plus
//            restart, which clears the scan and makes this word position 0.
//   rsp_*  : finished intervals (start, end); last_of_run marks the final
//            interval caused by one input word. An input word gives 0, 1 or 2.
//   csr_*  : index 0 min_length, index 1 max_bridge; csr_ready is always high.
// Timing: a word taken is held in the input register and evaluated from it
//   once the queue has room; its intervals are written into the result queue,
//   and rsp_valid shows the first of them from the queue registers.
// Throughput: one word per cycle unless stalled. Evaluation is one pass through
//   subtract/compare logic between the input register and a 4-entry result
//   queue; a word is evaluated only when the queue has two free entries.
// Receiver stall: results wait in the queue; once it fills past two entries
//   the input register holds and req_ready drops. A two-interval word drains
//   as two rsp words.
// Reset: state goes idle, position 0, registers to 10000 and 600000, queue
//   empty. No clearing pass is needed.
module bridged_run_segmenter
   import brs_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_symbol,
   input  logic                req_restart,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [OUT_BITS-1:0] rsp_region_start,
   output logic [OUT_BITS-1:0] rsp_region_end,
   output logic                rsp_last_of_run,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   localparam int CMP_BITS = (POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS;

   typedef logic [POSITION_BITS-1:0] pos_type;

   // configuration
   logic [CFG_BITS-1:0] min_len_ff, max_brg_ff;

   // input register
   logic       in_vld_ff;
   logic [1:0] in_sym_ff;
   logic       in_rst_ff;

   // scan state
   state_type st_ff, st_in, cur_st;
   pos_type   pos_ff, prev_ff;
   pos_type   run_start_ff, run_start_in, rs;
   pos_type   run_end_ff, run_end_in, re;
   pos_type   gap_end_ff, gap_end_in, ge;
   pos_type   gap_len_ff, gap_len_in, gl;
   logic      gap_vld_ff, gap_vld_in, gv;
   logic      bridging_ff, bridging_in, br;
   pos_type   cur_pos, cur_prev;

   // result queue
   logic [OUT_BITS-1:0]  q_start_ff [QDEPTH];
   logic [OUT_BITS-1:0]  q_end_ff   [QDEPTH];
   logic                 q_last_ff  [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] q_cnt_ff;

   logic    advance, pop;
   pos_type len_prev, len_run, len_tail, gap_new;
   logic    prev_ok, run_ok, tail_ok, gap_le, gap_big;
   logic    e0_v, e0_run, e1_v;
   pos_type first_s, first_e, e1_s;
   logic [1:0] push_n;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LENGTH_RST;
         max_brg_ff <= MAX_BRIDGE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LENGTH: min_len_ff <= csr_wdata;
            CSR_MAX_BRIDGE: max_brg_ff <= csr_wdata;
         endcase
      end
   end

   assign advance   = in_vld_ff && (q_cnt_ff <= QCNT_BITS'(QDEPTH - 2));
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_sym_ff <= req_symbol;
         in_rst_ff <= req_restart;
      end
   end

   // restart takes effect before the word is evaluated
   assign cur_st   = in_rst_ff ? ST_IDLE : st_ff;
   assign cur_pos  = in_rst_ff ? '0 : pos_ff;
   assign cur_prev = in_rst_ff ? '1 : prev_ff;
   assign rs       = in_rst_ff ? '0 : run_start_ff;
   assign re       = in_rst_ff ? '0 : run_end_ff;
   assign ge       = in_rst_ff ? '0 : gap_end_ff;
   assign gl       = gap_len_ff;
   assign gv       = in_rst_ff ? 1'b0 : gap_vld_ff;
   assign br       = in_rst_ff ? 1'b0 : bridging_ff;

   // modular lengths; prev - gap_end - 1 == prev + ~gap_end
   assign len_prev = cur_prev - rs;
   assign len_run  = re - rs;
   assign len_tail = cur_prev + ~ge;
   assign gap_new  = cur_prev - re;

   assign prev_ok = CMP_BITS'(len_prev) >= CMP_BITS'(min_len_ff);
   assign run_ok  = CMP_BITS'(len_run)  >= CMP_BITS'(min_len_ff);
   assign tail_ok = CMP_BITS'(len_tail) >= CMP_BITS'(min_len_ff);
   assign gap_le  = !gv || (CMP_BITS'(gl) <= CMP_BITS'(max_brg_ff));
   assign gap_big = CMP_BITS'(gap_new) > CMP_BITS'(max_brg_ff);

   always_comb begin
      st_in        = cur_st;
      run_start_in = rs;
      run_end_in   = re;
      gap_end_in   = ge;
      gap_len_in   = gl;
      gap_vld_in   = gv;
      bridging_in  = br;
      e0_v         = 1'b0;
      e0_run       = 1'b0;   // 1: (start, run_end), 0: (start, prev)
      e1_v         = 1'b0;
      unique case (cur_st)
         ST_IDLE: begin
            gap_vld_in  = 1'b0;
            bridging_in = 1'b0;
            case (in_sym_ff)
               SYM_REGION: begin
                  run_start_in = cur_pos;
                  run_end_in   = cur_pos;
                  st_in        = ST_REGION;
               end
               SYM_PAD: st_in = ST_PAD;
               default: ;
            endcase
         end
         ST_REGION: begin
            case (in_sym_ff)
               SYM_EMPTY: begin
                  if (!br && prev_ok) begin
                     e0_v = 1'b1;
                  end else if (gap_le) begin
                     e0_v = prev_ok;
                  end else begin
                     // split: stored run, then the tail after the gap
                     e0_v   = run_ok;
                     e0_run = 1'b1;
                     e1_v   = tail_ok;
                  end
                  st_in = ST_IDLE;
               end
               SYM_PAD: begin
                  run_end_in  = cur_prev;
                  st_in       = ST_PAD_AFTER;
                  bridging_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_PAD: begin
            case (in_sym_ff)
               SYM_EMPTY: st_in = ST_IDLE;
               SYM_REGION: begin
                  run_start_in = cur_pos;
                  run_end_in   = cur_pos;
                  st_in        = ST_REGION;
                  bridging_in  = 1'b0;
               end
               default: ;
            endcase
         end
         ST_PAD_AFTER: begin
            case (in_sym_ff)
               SYM_EMPTY: begin
                  e0_v        = run_ok;
                  e0_run      = 1'b1;
                  st_in       = ST_IDLE;
                  bridging_in = 1'b0;
               end
               SYM_REGION: begin
                  gap_end_in = cur_prev;
                  gap_len_in = gap_new;
                  gap_vld_in = 1'b1;
                  st_in      = ST_REGION;
                  if (gap_big) begin
                     e0_v         = run_ok;
                     e0_run       = 1'b1;
                     run_start_in = cur_pos;
                     run_end_in   = cur_pos;
                  end
               end
               default: ;
            endcase
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pos_ff       <= '0;
         prev_ff      <= '1;
         run_start_ff <= '0;
         run_end_ff   <= '0;
         gap_end_ff   <= '0;
         gap_len_ff   <= '1;
         gap_vld_ff   <= 1'b0;
         bridging_ff  <= 1'b0;
      end else if (advance) begin
         st_ff        <= st_in;
         pos_ff       <= cur_pos + 1'b1;
         prev_ff      <= cur_pos;
         run_start_ff <= run_start_in;
         run_end_ff   <= run_end_in;
         gap_end_ff   <= gap_end_in;
         gap_len_ff   <= gap_len_in;
         gap_vld_ff   <= gap_vld_in;
         bridging_ff  <= bridging_in;
      end
   end

   // queue push: first word is e0 if present, else e1
   assign e1_s    = ge + 1'b1;
   assign first_s = e0_v ? rs : e1_s;
   assign first_e = (e0_v && e0_run) ? re : cur_prev;
   assign push_n  = advance ? ({1'b0, e0_v} + {1'b0, e1_v}) : 2'd0;
   assign pop     = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_start_ff[wr_ptr_ff] <= OUT_BITS'(first_s);
         q_end_ff[wr_ptr_ff]   <= OUT_BITS'(first_e);
         q_last_ff[wr_ptr_ff]  <= !(e0_v && e1_v);
      end
      if (push_n == 2'd2) begin
         q_start_ff[wr_ptr_ff + 1'b1] <= OUT_BITS'(e1_s);
         q_end_ff[wr_ptr_ff + 1'b1]   <= OUT_BITS'(cur_prev);
         q_last_ff[wr_ptr_ff + 1'b1]  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(push_n);
         rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(pop);
         q_cnt_ff  <= q_cnt_ff + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
      end
   end

   assign rsp_valid        = q_cnt_ff != '0;
   assign rsp_region_start = q_start_ff[rd_ptr_ff];
   assign rsp_region_end   = q_end_ff[rd_ptr_ff];
   assign rsp_last_of_run  = q_last_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/brs_checker.sv -----
// Port-level checks for the bridged run segmenter, bound to the top level.
// Depends on brs_pkg and bridged_run_segmenter.
module brs_checker
   import brs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [OUT_BITS-1:0] rsp_region_start,
   input logic [OUT_BITS-1:0] rsp_region_end,
   input logic                rsp_last_of_run
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_region_start)
         && $stable(rsp_region_end) && $stable(rsp_last_of_run))
      else $error("rsp word changed while stalled");

   // both words of a pair are queued together, so the second follows at once
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("second word of a pair missing");

   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low right after reset");

endmodule

bind bridged_run_segmenter brs_checker u_brs_checker (.*);
